### design/ssym_pkg.sv
// Shared codes, widths and result type for the scoped symbol table.
`timescale 1ns / 1ps
`default_nettype none

package ssym_pkg;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int KEY_IN_W = 64;
    localparam int TYPE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OPEN_W   = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd1;
    localparam logic [OP_W-1:0] OP_POP      = 3'd2;
    localparam logic [OP_W-1:0] OP_DECLARE  = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_TOP = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND_ALL = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SCOPE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;

    // Result item, status in the lowest bits
    typedef struct packed {
        logic [OPEN_W-1:0]   open_scopes;
        logic [TYPE_W-1:0]   found_type;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

### design/ssym_ram.sv
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ssym_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one word, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/ssym_seq.sv
// Sequencer with the shared key comparator, scope level and result register.
`timescale 1ns / 1ps
`default_nettype none

module ssym_seq
    import ssym_pkg::*;
#(
    parameter int MAX_SCOPES  = 16,
    parameter int SCOPE_SLOTS = 64,
    parameter int KEY_BYTES   = 8,
    parameter int KEY_W       = 8 * KEY_BYTES,
    parameter int SC_W        = $clog2(MAX_SCOPES),
    parameter int FILL_W      = $clog2(SCOPE_SLOTS + 1),
    parameter int ADDR_W      = $clog2(MAX_SCOPES * SCOPE_SLOTS)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request side
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [KEY_IN_W-1:0] i_key,
    input  wire logic [TYPE_W-1:0]   i_type,
    // result side
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_result                  o_result,
    // scope fill RAM
    output logic                     o_fill_we,
    output logic [SC_W-1:0]          o_fill_waddr,
    output logic [FILL_W-1:0]        o_fill_wdata,
    output logic [SC_W-1:0]          o_fill_raddr,
    input  wire logic [FILL_W-1:0]   i_fill_rdata,
    // entry RAM
    output logic                     o_ent_we,
    output logic [ADDR_W-1:0]        o_ent_waddr,
    output logic [KEY_W-1:0]         o_ent_wkey,
    output logic [TYPE_W-1:0]        o_ent_wtype,
    output logic [ADDR_W-1:0]        o_ent_raddr,
    input  wire logic [KEY_W-1:0]    i_ent_rkey,
    input  wire logic [TYPE_W-1:0]   i_ent_rtype
);

    localparam int LVL_W = $clog2(MAX_SCOPES + 1);
    localparam logic [LVL_W-1:0]  DEPTH_L = LVL_W'(MAX_SCOPES);
    localparam logic [FILL_W-1:0] SLOTS_L = FILL_W'(SCOPE_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FRD  = 5'b00010,
        S_FGET = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [LVL_W-1:0]    r_level, n_level;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [SC_W-1:0]     r_scope, n_scope;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [FILL_W-1:0]   r_slot, n_slot;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [TYPE_W-1:0]   r_found, n_found;
    t_result             r_out, n_out;
    logic                in_xfer;
    logic                hit;

    // Entry address of a slot within a scope
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SC_W-1:0] s,
                                                    input logic [FILL_W-1:0] i);
        slot_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(SCOPE_SLOTS)) + ADDR_W'(i);
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign hit         = r_pend && (i_ent_rkey == r_key);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Sequence one operation
    always_comb begin
        n_state      = r_state;
        n_level      = r_level;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_key        = r_key;
        n_type       = r_type;
        n_scope      = r_scope;
        n_fill       = r_fill;
        n_slot       = r_slot;
        n_status     = r_status;
        n_found      = r_found;
        n_out        = r_out;
        o_fill_we    = 1'b0;
        o_fill_waddr = r_scope;
        o_fill_wdata = '0;
        o_fill_raddr = r_scope;
        o_ent_we     = 1'b0;
        o_ent_waddr  = slot_addr(r_scope, r_fill);
        o_ent_wkey   = r_key;
        o_ent_wtype  = r_type;
        o_ent_raddr  = slot_addr(r_scope, r_slot - FILL_W'(1));

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op     = i_op;
                    n_key    = i_key[KEY_W-1:0];
                    n_type   = i_type;
                    n_found  = '0;
                    n_status = ST_IGNORED;
                    n_state  = S_DONE;
                    case (i_op)
                        OP_CLEAR: begin
                            n_level  = '0;
                            n_status = ST_OK;
                        end
                        OP_PUSH: begin
                            if (r_level < DEPTH_L) begin
                                // open a scope with no entries
                                o_fill_we    = 1'b1;
                                o_fill_waddr = SC_W'(r_level);
                                n_level      = r_level + LVL_W'(1);
                                n_status     = ST_OK;
                            end
                        end
                        OP_POP: begin
                            if (r_level != '0) begin
                                n_level  = r_level - LVL_W'(1);
                                n_status = ST_OK;
                            end
                        end
                        OP_DECLARE, OP_FIND_TOP, OP_FIND_ALL: begin
                            if (r_level == '0) begin
                                n_status = ST_NO_SCOPE;
                            end else begin
                                n_scope = SC_W'(r_level - LVL_W'(1));
                                n_state = S_FRD;
                            end
                        end
                        default: begin
                            n_status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_FRD: begin
                n_state = S_FGET;
            end
            S_FGET: begin
                n_fill  = i_fill_rdata;
                n_slot  = i_fill_rdata;
                n_pend  = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hit) begin
                    // newest matching entry wins
                    n_pend = 1'b0;
                    if (r_op == OP_DECLARE) begin
                        n_status = ST_DUPLICATE;
                    end else begin
                        n_status = ST_OK;
                        n_found  = i_ent_rtype;
                    end
                    n_state = S_DONE;
                end else if (r_slot != '0) begin
                    // fetch the next older entry
                    n_slot = r_slot - FILL_W'(1);
                    n_pend = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else if (r_op == OP_DECLARE) begin
                    n_state = S_DONE;
                    if (r_fill >= SLOTS_L) begin
                        n_status = ST_FULL;
                    end else begin
                        // append the name and bump the fill
                        o_ent_we     = 1'b1;
                        o_fill_we    = 1'b1;
                        o_fill_wdata = r_fill + FILL_W'(1);
                        n_status     = ST_OK;
                    end
                end else if (r_op == OP_FIND_ALL && r_scope != '0) begin
                    // move one scope outward
                    n_scope = r_scope - SC_W'(1);
                    n_state = S_FRD;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.found_type  = r_found;
                    n_out.open_scopes = OPEN_W'(r_level);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_type   <= n_type;
        r_scope  <= n_scope;
        r_fill   <= n_fill;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= DEPTH_L)
        else $error("scope level beyond depth");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ent_we |-> (r_fill < SLOTS_L) && (r_op == OP_DECLARE))
        else $error("entry written into a full scope");

    a_found_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != ST_OK) |-> r_out.found_type == '0)
        else $error("type reported without a match");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion");
`endif

endmodule

`default_nettype wire

### design/scoped_symbol_table_core.sv
// Top level of the scoped symbol table: stream ports, RAMs and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Scoped symbol table. Each request on the slave stream does one operation
// (clear, push, pop, declare, lookup in the innermost scope, lookup across
// all open scopes) and gives exactly one response on the master stream.
// The block takes one request at a time. Clear, push, pop and unused codes
// go straight to the response. Declare and lookups scan the entry RAM with
// one shared key comparator, one entry per cycle, newest first: each scope
// searched takes a fill read, a scan and a drain, and a visible lookup
// moves one scope outward at a time until a match. A finished response
// waits in an output register, so the next request is taken while it is
// still pending.
// Entry storage is not cleared after reset; no initialisation pass is needed.
module scoped_symbol_table_core
    import ssym_pkg::*;
#(
    parameter int MAX_SCOPES  = 16,
    parameter int SCOPE_SLOTS = 64,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [2:0] op, [66:3] name_key, [74:67] type_code, [79:75] zero
    input  wire logic [79:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [2:0] status, [10:3] found_type, [15:11] open_scopes
    output logic [15:0]      o_m_axis_tdata
);

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int SC_W   = $clog2(MAX_SCOPES);
    localparam int FILL_W = $clog2(SCOPE_SLOTS + 1);
    localparam int ADDR_W = $clog2(MAX_SCOPES * SCOPE_SLOTS);

    logic [OP_W-1:0]          in_op;
    logic [KEY_IN_W-1:0]      in_key;
    logic [TYPE_W-1:0]        in_type;
    t_result                  result;
    logic                     fill_we;
    logic [SC_W-1:0]          fill_waddr;
    logic [FILL_W-1:0]        fill_wdata;
    logic [SC_W-1:0]          fill_raddr;
    logic [FILL_W-1:0]        fill_rdata;
    logic                     ent_we;
    logic [ADDR_W-1:0]        ent_waddr;
    logic [KEY_W-1:0]         ent_wkey;
    logic [TYPE_W-1:0]        ent_wtype;
    logic [ADDR_W-1:0]        ent_raddr;
    logic [KEY_W+TYPE_W-1:0]  ent_rdata;

    // Unpack the request
    assign in_op   = i_s_axis_tdata[2:0];
    assign in_key  = i_s_axis_tdata[66:3];
    assign in_type = i_s_axis_tdata[74:67];

    // Pack the response
    assign o_m_axis_tdata = result;

    ssym_seq #(
        .MAX_SCOPES  (MAX_SCOPES),
        .SCOPE_SLOTS (SCOPE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_op         (in_op),
        .i_key        (in_key),
        .i_type       (in_type),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_result     (result),
        .o_fill_we    (fill_we),
        .o_fill_waddr (fill_waddr),
        .o_fill_wdata (fill_wdata),
        .o_fill_raddr (fill_raddr),
        .i_fill_rdata (fill_rdata),
        .o_ent_we     (ent_we),
        .o_ent_waddr  (ent_waddr),
        .o_ent_wkey   (ent_wkey),
        .o_ent_wtype  (ent_wtype),
        .o_ent_raddr  (ent_raddr),
        .i_ent_rkey   (ent_rdata[KEY_W-1:0]),
        .i_ent_rtype  (ent_rdata[KEY_W+TYPE_W-1:KEY_W])
    );

    // Per-scope fill counts
    ssym_ram #(
        .DEPTH (MAX_SCOPES),
        .WIDTH (FILL_W)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    // Name keys with their type codes
    ssym_ram #(
        .DEPTH (MAX_SCOPES * SCOPE_SLOTS),
        .WIDTH (KEY_W + TYPE_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata ({ent_wtype, ent_wkey}),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

endmodule

`default_nettype wire
